### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### sv/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types, constants and helper functions of the pan/tilt command block.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned LEN_W = 6;
  localparam logic [LEN_W-1:0] LINE_MAX = 6'd49;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_AMP   = 8'h26;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [7:0] ANGLE_MAX  = 8'd180;
  localparam logic [7:0] ANGLE_OFS  = 8'd45;
  // 569/1024 sits just above 5/9; the error stays below one step for x <= 225
  localparam logic [16:0] CMP_RECIP = 17'd569;

  localparam logic [7:0] PAN_MAX_RST    = 8'd180;
  localparam logic [7:0] TILT_HOME_RST  = 8'd45;
  localparam logic [6:0] TILT_STEP_RST  = 7'd10;
  localparam logic [7:0] TILT_LIMIT_RST = 8'd135;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAN_MAX    = 2'd0,
    CFG_TILT_HOME  = 2'd1,
    CFG_TILT_STEP  = 2'd2,
    CFG_TILT_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_MANUAL = 3'd1,
    KIND_AUTO   = 3'd2,
    KIND_STOP   = 3'd3,
    KIND_POS    = 3'd4,
    KIND_OTHER  = 3'd5
  } line_kind_e;

  // Parser to sweep: mode after this item, and a direct position request
  typedef struct packed {
    logic       manual;
    logic       stopped;
    logic       pos_load;
    logic [7:0] pos_pan;
    logic [7:0] pos_tilt;
  } parse_ctl_t;

  typedef struct packed {
    line_kind_e kind;
    logic       stopped;
    logic       manual;
    logic [6:0] tilt_cmp;
    logic [6:0] pan_cmp;
  } result_t;

  function automatic logic [7:0] kw_manual_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h6D; // m
      3'd1:    c = 8'h61; // a
      3'd2:    c = 8'h6E; // n
      3'd3:    c = 8'h75; // u
      3'd4:    c = 8'h61; // a
      3'd5:    c = 8'h6C; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_auto_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h61; // a
      2'd1:    c = 8'h75; // u
      2'd2:    c = 8'h74; // t
      2'd3:    c = 8'h6F; // o
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_stop_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h73; // s
      2'd1:    c = 8'h74; // t
      2'd2:    c = 8'h6F; // o
      2'd3:    c = 8'h70; // p
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Negative numbers go to zero, large ones to the top of the servo range
  function automatic logic [7:0] finish_number(input logic [7:0] v, input logic neg);
    logic [7:0] r;
    if (neg) begin
      r = 8'd0;
    end else if (v > ANGLE_MAX) begin
      r = ANGLE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // floor((min(a,180)+45)*5/9) by reciprocal multiply
  function automatic logic [6:0] to_compare(input logic [7:0] a);
    logic [7:0]  x;
    logic [16:0] p;
    x = (a > ANGLE_MAX) ? ANGLE_MAX : a;
    x = x + ANGLE_OFS;
    p = {9'd0, x} * CMP_RECIP;
    return p[16:10];
  endfunction

endpackage

### sv/spt_line_parser.sv
// ----------------------------------------------------------------------------
// spt_line_parser
// Collects received characters into a line, matches the keywords, parses the
// n&m position text and classifies the line at carriage return.
// ----------------------------------------------------------------------------
module spt_line_parser #(
  parameter logic [spt_pkg::LEN_W-1:0] LINE_MAX = spt_pkg::LINE_MAX
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    byte_i,
  input  logic [7:0]              data_i,
  output spt_pkg::parse_ctl_t     ctl_o,
  output spt_pkg::line_kind_e     kind_o
);

  logic [spt_pkg::LEN_W-1:0] len_q, len_d;
  logic [2:0]                kw_q, kw_d;
  logic                      in2_q, in2_d;
  logic                      done_q, done_d;
  logic [7:0]                n1_q, n1_d;
  logic [7:0]                n2_q, n2_d;
  logic [1:0]                sign_q, sign_d;
  logic                      manual_q, manual_d;
  logic                      stop_q, stop_d;

  logic [7:0]  cur;
  logic [11:0] acc;
  logic [2:0]  kw_hit;
  logic        is_digit;
  logic        is_blank;
  spt_pkg::line_kind_e kind;

  always_comb begin
    len_d    = len_q;
    kw_d     = kw_q;
    in2_d    = in2_q;
    done_d   = done_q;
    n1_d     = n1_q;
    n2_d     = n2_q;
    sign_d   = sign_q;
    manual_d = manual_q;
    stop_d   = stop_q;
    kind     = spt_pkg::KIND_NONE;
    cur      = in2_q ? n2_q : n1_q;
    acc      = {4'd0, cur} * 12'd10 + {4'd0, data_i - spt_pkg::CHAR_ZERO};
    is_digit = (data_i >= spt_pkg::CHAR_ZERO) && (data_i <= spt_pkg::CHAR_NINE);
    is_blank = ((data_i >= spt_pkg::CHAR_TAB) && (data_i <= spt_pkg::CHAR_FF)) ||
               (data_i == spt_pkg::CHAR_SPACE);
    kw_hit[0] = kw_q[0] && (len_q < 6'd6) &&
                (data_i == spt_pkg::kw_manual_char(len_q[2:0]));
    kw_hit[1] = kw_q[1] && (len_q < 6'd4) &&
                (data_i == spt_pkg::kw_auto_char(len_q[1:0]));
    kw_hit[2] = kw_q[2] && (len_q < 6'd4) &&
                (data_i == spt_pkg::kw_stop_char(len_q[1:0]));

    ctl_o.pos_load = 1'b0;
    ctl_o.pos_pan  = n1_q;
    ctl_o.pos_tilt = spt_pkg::finish_number(n2_q, sign_q[0]);

    if (byte_i && (data_i == spt_pkg::CHAR_CR)) begin
      if (kw_q[0] && (len_q == 6'd6)) begin
        kind = spt_pkg::KIND_MANUAL;
      end else if (kw_q[1] && (len_q == 6'd4)) begin
        kind = spt_pkg::KIND_AUTO;
      end else if (kw_q[2] && (len_q == 6'd4)) begin
        kind = spt_pkg::KIND_STOP;
      end else if (in2_q) begin
        kind = spt_pkg::KIND_POS;
      end else begin
        kind = spt_pkg::KIND_OTHER;
      end
      stop_d = (kind == spt_pkg::KIND_STOP);
      if (kind == spt_pkg::KIND_MANUAL) begin
        manual_d = 1'b1;
      end
      if (kind == spt_pkg::KIND_AUTO) begin
        manual_d = 1'b0;
      end
      ctl_o.pos_load = (kind == spt_pkg::KIND_POS) && manual_q;
      // clear the line
      len_d  = '0;
      kw_d   = 3'b111;
      in2_d  = 1'b0;
      done_d = 1'b0;
      n1_d   = '0;
      n2_d   = '0;
      sign_d = '0;
    end else if (byte_i && (len_q < LINE_MAX)) begin
      kw_d  = kw_hit;
      len_d = len_q + 1'b1;
      if ((data_i == spt_pkg::CHAR_AMP) && !in2_q) begin
        n1_d   = spt_pkg::finish_number(n1_q, sign_q[0]);
        in2_d  = 1'b1;
        done_d = 1'b0;
        sign_d = '0;
        n2_d   = '0;
      end else if (!done_q) begin
        if (is_digit) begin
          cur       = (acc > 12'd255) ? 8'd255 : acc[7:0];
          sign_d[1] = 1'b1;
        end else if (!sign_q[1] &&
                     ((data_i == spt_pkg::CHAR_PLUS) || (data_i == spt_pkg::CHAR_MINUS))) begin
          sign_d = {1'b1, data_i == spt_pkg::CHAR_MINUS};
        end else if (!(!sign_q[1] && is_blank)) begin
          done_d = 1'b1;
        end
        if (in2_q) begin
          n2_d = cur;
        end else begin
          n1_d = cur;
        end
      end
    end

    ctl_o.manual  = manual_d;
    ctl_o.stopped = stop_d;
    kind_o        = kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      kw_q     <= 3'b111;
      in2_q    <= 1'b0;
      done_q   <= 1'b0;
      n1_q     <= '0;
      n2_q     <= '0;
      sign_q   <= '0;
      manual_q <= 1'b0;
      stop_q   <= 1'b0;
    end else begin
      len_q    <= len_d;
      kw_q     <= kw_d;
      in2_q    <= in2_d;
      done_q   <= done_d;
      n1_q     <= n1_d;
      n2_q     <= n2_d;
      sign_q   <= sign_d;
      manual_q <= manual_d;
      stop_q   <= stop_d;
    end
  end

endmodule

### sv/spt_sweep.sv
// ----------------------------------------------------------------------------
// spt_sweep
// Holds the sweep settings, the pan/tilt sweep angles and the two PWM
// compare registers; steps the sweep on each tick in auto mode unless stopped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spt_sweep (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [spt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              tick_i,
  input  spt_pkg::parse_ctl_t               ctl_i,
  output logic [6:0]                        pan_cmp_o,
  output logic [6:0]                        tilt_cmp_o
);

  logic [7:0] pan_max_q;
  logic [7:0] tilt_home_q;
  logic [6:0] tilt_step_q;
  logic [7:0] tilt_limit_q;

  logic [7:0] pan_ang_q, pan_ang_d;
  logic       down_q, down_d;
  logic [7:0] tilt_ang_q, tilt_ang_d;
  logic [6:0] pan_cmp_q, pan_cmp_d;
  logic [6:0] tilt_cmp_q, tilt_cmp_d;

  logic [8:0] tilt_sum;
  logic [7:0] tilt_add;
  logic [7:0] pan_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_max_q    <= spt_pkg::PAN_MAX_RST;
      tilt_home_q  <= spt_pkg::TILT_HOME_RST;
      tilt_step_q  <= spt_pkg::TILT_STEP_RST;
      tilt_limit_q <= spt_pkg::TILT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (spt_pkg::cfg_idx_e'(cfg_idx_i))
        spt_pkg::CFG_PAN_MAX:    pan_max_q    <= cfg_data_i;
        spt_pkg::CFG_TILT_HOME:  tilt_home_q  <= cfg_data_i;
        spt_pkg::CFG_TILT_STEP:  tilt_step_q  <= cfg_data_i[6:0];
        spt_pkg::CFG_TILT_LIMIT: tilt_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pan_ang_d  = pan_ang_q;
    down_d     = down_q;
    tilt_ang_d = tilt_ang_q;
    pan_cmp_d  = pan_cmp_q;
    tilt_cmp_d = tilt_cmp_q;
    // saturating tilt increment, used at either end of the pan sweep
    tilt_sum   = {1'b0, tilt_ang_q} + {2'b00, tilt_step_q};
    tilt_add   = tilt_sum[8] ? 8'd255 : tilt_sum[7:0];
    pan_step   = pan_ang_q;

    if (ctl_i.pos_load) begin
      pan_cmp_d  = spt_pkg::to_compare(ctl_i.pos_pan);
      tilt_cmp_d = spt_pkg::to_compare(ctl_i.pos_tilt);
    end

    if (tick_i && !ctl_i.manual) begin
      pan_cmp_d  = spt_pkg::to_compare(pan_ang_q);
      tilt_cmp_d = spt_pkg::to_compare(tilt_ang_q);
      if (!ctl_i.stopped) begin
        if (!down_q) begin
          pan_step = (pan_ang_q < pan_max_q) ? pan_ang_q + 8'd1 : pan_ang_q;
          if (pan_step >= pan_max_q) begin
            pan_ang_d  = pan_max_q;
            down_d     = 1'b1;
            tilt_ang_d = tilt_add;
          end else begin
            pan_ang_d = pan_step;
          end
        end else begin
          pan_step  = (pan_ang_q != 8'd0) ? pan_ang_q - 8'd1 : pan_ang_q;
          pan_ang_d = pan_step;
          if (pan_step == 8'd0) begin
            down_d     = 1'b0;
            tilt_ang_d = (tilt_add >= tilt_limit_q) ? tilt_home_q : tilt_add;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_ang_q  <= '0;
      down_q     <= 1'b0;
      tilt_ang_q <= spt_pkg::TILT_HOME_RST;
      pan_cmp_q  <= '0;
      tilt_cmp_q <= '0;
    end else begin
      pan_ang_q  <= pan_ang_d;
      down_q     <= down_d;
      tilt_ang_q <= tilt_ang_d;
      pan_cmp_q  <= pan_cmp_d;
      tilt_cmp_q <= tilt_cmp_d;
    end
  end

  assign pan_cmp_o  = pan_cmp_d;
  assign tilt_cmp_o = tilt_cmp_d;

  `ASSERT_NEVER(a_pan_cmp_range, clk_i, rst_ni, pan_cmp_q > 7'd125,
                "pan compare out of range")
  `ASSERT_NEVER(a_tilt_cmp_range, clk_i, rst_ni, tilt_cmp_q > 7'd125,
                "tilt compare out of range")
  `ASSERT_PROP(a_manual_tick_hold, clk_i, rst_ni,
               (tick_i && ctl_i.manual) |=>
               (pan_ang_q == $past(pan_ang_q)) && (pan_cmp_q == $past(pan_cmp_q)),
               "tick moved servo in manual mode")
  `ASSERT_PROP(a_stopped_hold, clk_i, rst_ni,
               (tick_i && ctl_i.stopped) |=>
               (pan_ang_q == $past(pan_ang_q)) && (tilt_ang_q == $past(tilt_ang_q)),
               "sweep moved while stopped")

endmodule

### sv/servo_pan_tilt_sweep_command_top.sv
// ----------------------------------------------------------------------------
// servo_pan_tilt_sweep_command_top
// Two-servo pan/tilt controller driven by received text lines and sweep ticks.
// ----------------------------------------------------------------------------
// Input stream: each request is a received character (tuser low, tdata the
// byte) or a 10 ms sweep tick (tuser high, tdata ignored). Carriage return
// ends a line: "manual", "auto", "stop" or a position command n&m.
// Output stream: exactly one result per input request, carrying both PWM
// compare values, the mode, the stop flag and the kind of line just ended.
// Configuration: write pan_max, tilt_home, tilt_step and tilt_limit through
// cfg_we_i/cfg_idx_i/cfg_data_i while no request is in flight.
// Each result is registered in the output register, or in the skid register
// if that is full. Throughput: one request per cycle while tready is high,
// set by the single pass from parser and sweep state into the result register.
// Stall: a two-entry result buffer (output register plus skid) keeps taking
// requests while one result waits; tready drops only when both hold data.
// Reset: auto mode, pan 0 rising, tilt 45, compares 0, settings to defaults,
// result buffer empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_pan_tilt_sweep_command_top #(
  // longest kept line; later characters are dropped
  parameter logic [spt_pkg::LEN_W-1:0] LINE_MAX = spt_pkg::LINE_MAX
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] rx_byte
  input  logic                           s_axis_tuser_i,  // [0] op
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [6:0] pan_compare, [13:7] tilt_compare, [14] manual_mode,
  // [15] sweep_stopped, [18:16] line_kind, [23:19] zero
  output logic [23:0]                    m_axis_tdata_o
);

  spt_pkg::parse_ctl_t ctl;
  spt_pkg::line_kind_e kind;
  spt_pkg::result_t    res;
  spt_pkg::result_t    out_data_q;
  spt_pkg::result_t    skid_data_q;
  logic                out_v_q;
  logic                skid_v_q;
  logic                accept;
  logic                out_free;
  logic [6:0]          pan_cmp;
  logic [6:0]          tilt_cmp;

  // take a request whenever the skid slot is empty
  assign s_axis_tready_o = !skid_v_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_v_q || m_axis_tready_i;

  spt_line_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (accept && !s_axis_tuser_i),
    .data_i (s_axis_tdata_i),
    .ctl_o  (ctl),
    .kind_o (kind)
  );

  spt_sweep u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_i     (accept && s_axis_tuser_i),
    .ctl_i      (ctl),
    .pan_cmp_o  (pan_cmp),
    .tilt_cmp_o (tilt_cmp)
  );

  always_comb begin
    res.kind     = kind;
    res.stopped  = ctl.stopped;
    res.manual   = ctl.manual;
    res.tilt_cmp = tilt_cmp;
    res.pan_cmp  = pan_cmp;
  end

  // result buffer control: drain skid first, else load the fresh result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= accept;
      end
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  // payload holds, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_v_q ? skid_data_q : res;
    end else if (accept) begin
      skid_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {5'd0, out_data_q};

  `ASSERT_NEVER(a_skid_needs_out, clk_i, rst_ni, skid_v_q && !out_v_q,
                "skid full with output empty")
  `ASSERT_PROP(a_skid_drain, clk_i, rst_ni,
               (skid_v_q && m_axis_tready_i) |=>
               out_v_q && (out_data_q == $past(skid_data_q)),
               "skid result lost on drain")
  `ASSERT_PROP(a_accept_shows, clk_i, rst_ni,
               (accept && !out_v_q) |=> out_v_q && !skid_v_q,
               "accepted request gave no result")

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pan/tilt servo command block testbench
// Streams text lines and sweep ticks into the block and checks every result
// against a cycle-free prediction of the parser, the sweep and the compares.
// ----------------------------------------------------------------------------
module testbench;
  import spt_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i;  // [7:0] rx_byte
  logic                  s_axis_tuser_i;  // [0] op
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // [6:0] pan_compare, [13:7] tilt_compare, [14] manual_mode,
  // [15] sweep_stopped, [18:16] line_kind, [23:19] zero
  logic [23:0]           m_axis_tdata_o;

  servo_pan_tilt_sweep_command_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // --------------------------------------------------------------------------
  // Predicted block state: settings, line parser, mode and sweep
  // --------------------------------------------------------------------------
  logic [7:0] pan_max_q    = PAN_MAX_RST;
  logic [7:0] tilt_home_q  = TILT_HOME_RST;
  logic [6:0] tilt_step_q  = TILT_STEP_RST;
  logic [7:0] tilt_limit_q = TILT_LIMIT_RST;

  logic [LEN_W-1:0] line_len = '0;
  logic [2:0]       kw_alive = 3'b111;  // bit0 manual, bit1 auto, bit2 stop
  logic             in_second = 1'b0;
  logic             num_done = 1'b0;
  logic [7:0]       num_pan = '0;
  logic [7:0]       num_tilt = '0;
  logic [1:0]       num_sign = '0;      // bit0 negative, bit1 number begun
  logic             manual_m = 1'b0;
  logic             stopped_m = 1'b0;
  logic [7:0]       pan_ang = '0;
  logic             pan_down = 1'b0;
  logic [7:0]       tilt_ang = TILT_HOME_RST;
  logic [6:0]       pan_cmp_m = '0;
  logic [6:0]       tilt_cmp_m = '0;

  string kw_manual = "manual";
  string kw_auto   = "auto";
  string kw_stop   = "stop";

  result_t awaited_results[$];
  int      mismatch_count = 0;
  int      requests_sent = 0;
  int      burst_left = 0;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Exact servo compare: floor((min(a,180)+45)*5/9)
  function automatic logic [6:0] angle_to_cmp(input logic [7:0] a);
    int x;
    x = (a > ANGLE_MAX) ? ANGLE_MAX : a;
    x = (x + ANGLE_OFS) * 5 / 9;
    return x[6:0];
  endfunction

  // Drop negative numbers to zero, cap the rest at the servo range
  function automatic logic [7:0] clamp_number(input logic [7:0] v, input logic neg);
    if (neg) return 8'd0;
    return (v > ANGLE_MAX) ? ANGLE_MAX : v;
  endfunction

  // Add the tilt increment, saturating at the top of the 8-bit angle
  function automatic logic [7:0] tilt_after_step(input logic [7:0] t);
    int s;
    s = t + tilt_step_q;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic result_t predict_servo_result(input logic op, input logic [7:0] ch);
    result_t    r;
    line_kind_e kind;
    logic [2:0] still;
    int         v;
    kind = KIND_NONE;
    if (op == OP_TICK) begin
      // Manual mode ignores ticks; a stopped sweep only refreshes compares
      if (!manual_m) begin
        pan_cmp_m  = angle_to_cmp(pan_ang);
        tilt_cmp_m = angle_to_cmp(tilt_ang);
        if (!stopped_m) begin
          if (!pan_down) begin
            if (pan_ang < pan_max_q) pan_ang = pan_ang + 1'b1;
            if (pan_ang >= pan_max_q) begin
              pan_ang  = pan_max_q;
              pan_down = 1'b1;
              tilt_ang = tilt_after_step(tilt_ang);
            end
          end else begin
            if (pan_ang > 0) pan_ang = pan_ang - 1'b1;
            if (pan_ang == 0) begin
              pan_down = 1'b0;
              tilt_ang = tilt_after_step(tilt_ang);
              if (tilt_ang >= tilt_limit_q) tilt_ang = tilt_home_q;
            end
          end
        end
      end
    end else if (ch == CHAR_CR) begin
      if (kw_alive[0] && line_len == 6) kind = KIND_MANUAL;
      else if (kw_alive[1] && line_len == 4) kind = KIND_AUTO;
      else if (kw_alive[2] && line_len == 4) kind = KIND_STOP;
      else if (in_second) kind = KIND_POS;
      else kind = KIND_OTHER;
      stopped_m = (kind == KIND_STOP);
      if (kind == KIND_MANUAL) manual_m = 1'b1;
      if (kind == KIND_AUTO) manual_m = 1'b0;
      if (kind == KIND_POS && manual_m) begin
        pan_cmp_m  = angle_to_cmp(num_pan);
        tilt_cmp_m = angle_to_cmp(clamp_number(num_tilt, num_sign[0]));
      end
      line_len  = '0;
      kw_alive  = 3'b111;
      in_second = 1'b0;
      num_done  = 1'b0;
      num_pan   = '0;
      num_tilt  = '0;
      num_sign  = '0;
    end else if (line_len < LINE_MAX) begin
      // Keep each keyword alive only while the line still spells it
      still[0] = kw_alive[0] && line_len < 6 && ch == kw_manual[line_len];
      still[1] = kw_alive[1] && line_len < 4 && ch == kw_auto[line_len];
      still[2] = kw_alive[2] && line_len < 4 && ch == kw_stop[line_len];
      kw_alive = still;
      line_len = line_len + 1'b1;
      if (ch == CHAR_AMP && !in_second) begin
        num_pan   = clamp_number(num_pan, num_sign[0]);
        in_second = 1'b1;
        num_done  = 1'b0;
        num_sign  = '0;
        num_tilt  = '0;
      end else if (!num_done) begin
        v = in_second ? num_tilt : num_pan;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          v = v * 10 + (ch - CHAR_ZERO);
          if (v > 255) v = 255;
          num_sign[1] = 1'b1;
        end else if (!num_sign[1] && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
          num_sign = {1'b1, ch == CHAR_MINUS};
        end else if (!num_sign[1] &&
                     ((ch >= CHAR_TAB && ch <= CHAR_FF) || ch == CHAR_SPACE)) begin
          // leading blank, skip it
        end else begin
          num_done = 1'b1;
        end
        if (in_second) num_tilt = v[7:0];
        else num_pan = v[7:0];
      end
    end
    r.pan_cmp  = pan_cmp_m;
    r.tilt_cmp = tilt_cmp_m;
    r.manual   = manual_m;
    r.stopped  = stopped_m;
    r.kind     = kind;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: bursts of back-to-back requests with random gaps
  // --------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      // Zero gap keeps a stretch running without any idle cycle
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= ch;
    do @(posedge clk_i); while (!s_axis_tready_o);
    awaited_results.push_back(predict_servo_result(op, ch));
    requests_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    send_request(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Send the text of one line and the carriage return that ends it
  task automatic send_line(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_request(OP_BYTE, text[i]);
    send_request(OP_BYTE, CHAR_CR);
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write all four settings on consecutive cycles; block must be idle
  task automatic write_settings(input logic [7:0] pan_top, input logic [7:0] home,
                                input logic [7:0] step, input logic [7:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PAN_MAX;
    cfg_data_i <= pan_top;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TILT_HOME;
    cfg_data_i <= home;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TILT_STEP;
    cfg_data_i <= step;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TILT_LIMIT;
    cfg_data_i <= limit;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pan_max_q    = pan_top;
    tilt_home_q  = home;
    tilt_step_q  = step[6:0];
    tilt_limit_q = limit;
  endtask

  // One number of a position command: optional blanks, sign and digits
  function automatic string number_text();
    string s;
    s = "";
    case ($urandom_range(0, 5))
      0: s = " ";
      1: s = "\t ";
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: s = {s, "-"};
      1: s = {s, "+"};
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: ;  // no digits at all reads as zero
      1: s = {s, $sformatf("%0d", $urandom_range(181, 99999))};
      2: s = {s, "007"};
      default: s = {s, $sformatf("%0d", $urandom_range(0, 180))};
    endcase
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Keywords, saturating position command, ticks in manual and stopped modes
  task automatic test_directed_lines();
    send_line("manual");
    send_tick();
    send_line(" -5&300/");
    send_line("auto");
    send_line("stop");
    send_tick();
    send_line("");
    send_tick();
  endtask

  // Run the automatic sweep under one setting, with a stop in the middle
  task automatic test_sweep(input logic [7:0] pan_top, input logic [7:0] home,
                            input logic [7:0] step, input logic [7:0] limit,
                            input int ticks);
    int i;
    wait_idle();
    write_settings(pan_top, home, step, limit);
    send_line("auto");
    for (i = 0; i < ticks; i++) begin
      if (i == ticks / 2) send_line("stop");
      if (i == ticks / 2 + 4) send_line("");
      send_tick();
    end
  endtask

  // Mostly well-formed lines and tick bursts, some noise and broken lines
  task automatic test_random_traffic(input int count);
    int         stop_at;
    int         next_cfg;
    int         n;
    int         i;
    int         pick;
    logic [7:0] ch;
    stop_at  = requests_sent + count;
    next_cfg = requests_sent + 150;
    while (requests_sent < stop_at) begin
      if (requests_sent >= next_cfg) begin
        wait_idle();
        if ($urandom_range(0, 3) == 0)
          write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
          write_settings(8'($urandom_range(1, 12)), 8'($urandom_range(0, 180)),
                         8'($urandom_range(0, 90)), 8'($urandom_range(0, 180)));
        next_cfg += 150;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = $urandom_range(1, 10);
        repeat (n) send_tick();
      end else if (pick < 50) begin
        case ($urandom_range(0, 4))
          0: send_line({number_text(), "&", number_text()});
          1: send_line({number_text(), "&", number_text(), "/x9"});
          2: send_line({number_text(), "&", number_text(), "&5"});
          default: send_line({number_text(), "&", number_text(), "/"});
        endcase
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0, 1: send_line("manual");
          2: send_line("auto");
          default: send_line("stop");
        endcase
      end else if (pick < 75) begin
        case ($urandom_range(0, 7))
          0: send_line("manua");
          1: send_line("manualx");
          2: send_line("autos");
          3: send_line("Auto");
          4: send_line("sto");
          5: send_line("stop ");
          6: send_line("xstop");
          default: send_line("au&to");
        endcase
      end else if (pick < 88) begin
        // Raw bytes, zero and high bytes included; length zero gives an empty line
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++) begin
          ch = 8'($urandom_range(0, 255));
          if (ch == CHAR_CR) ch = 8'd0;
          send_request(OP_BYTE, ch);
        end
        send_request(OP_BYTE, CHAR_CR);
      end else if (pick < 94) begin
        // Line near or past the limit: bytes past the line limit must be dropped
        n = $urandom_range(LINE_MAX - 4, 62);
        for (i = 0; i < n; i++) begin
          if (i < 4 && pick == 88) ch = kw_stop[i];
          else if (i == LINE_MAX - 1 + (pick & 1)) ch = CHAR_AMP;
          else ch = 8'($urandom_range(0, 255));
          if (ch == CHAR_CR) ch = CHAR_NINE;
          send_request(OP_BYTE, ch);
        end
        send_request(OP_BYTE, CHAR_CR);
      end else begin
        // Unfinished fragment that merges into the next line
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) begin
          ch = 8'($urandom_range(32, 126));
          send_request(OP_BYTE, ch);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: stall pattern and checking
  // --------------------------------------------------------------------------
  initial begin : result_stalls
    int style;
    int span;
    m_axis_tready_i = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 120);
      repeat (span) begin
        @(negedge clk_i);
        case (style)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= $urandom_range(0, 1);
          2: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready_i <= ($urandom_range(0, 9) == 0);  // long stalls
        endcase
      end
    end
  end

  function automatic void report_mismatch(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result with none awaited, expected nothing, actual %h",
                 $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        got  = m_axis_tdata_o[18:0];
        if (got.pan_cmp !== want.pan_cmp)
          report_mismatch("pan_compare", {1'b0, want.pan_cmp}, {1'b0, got.pan_cmp});
        if (got.tilt_cmp !== want.tilt_cmp)
          report_mismatch("tilt_compare", {1'b0, want.tilt_cmp}, {1'b0, got.tilt_cmp});
        if (got.manual !== want.manual)
          report_mismatch("manual_mode", {7'd0, want.manual}, {7'd0, got.manual});
        if (got.stopped !== want.stopped)
          report_mismatch("sweep_stopped", {7'd0, want.stopped}, {7'd0, got.stopped});
        if (got.kind !== want.kind)
          report_mismatch("line_kind", {5'd0, want.kind}, {5'd0, got.kind});
        if (m_axis_tdata_o[23:19] !== 5'd0)
          report_mismatch("padding", 8'd0, {3'd0, m_axis_tdata_o[23:19]});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PAN_MAX;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_BYTE;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_lines();
    // Default settings past the top reversal, then tight sweeps that wrap and
    // saturate tilt
    test_sweep(PAN_MAX_RST, TILT_HOME_RST, TILT_STEP_RST, TILT_LIMIT_RST, 200);
    test_sweep(8'd1, 8'd0, 8'd0, 8'd0, 30);
    test_sweep(8'd5, 8'd180, 8'd90, 8'd180, 40);
    test_sweep(8'd7, 8'd20, 8'd7, 8'd60, 80);
    // Out-of-range settings: pan pinned at zero, tilt home above the servo range
    test_sweep(8'd0, 8'hFF, 8'hFF, 8'hFF, 20);
    test_random_traffic(250);

    wait_idle();
    repeat (3) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
